// ----- rtl/core/plbh_pkg.sv -----
// Shared types and constants for the parallel byte link block.
`timescale 1ns / 1ps

package plbh_pkg;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] BYTE_IDLE = 8'hFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_READER_EN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_XFER_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_TICKS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_TIMEOUT = 2'd3;

   typedef enum logic [2:0] {
      TX_IDLE,
      TX_XFER,
      TX_WAIT,
      TX_OK,
      TX_INTR
   } tx_status_type;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_SEND,
      CMD_POP,
      CMD_REMOTE,
      CMD_ABORT,
      CMD_NOP
   } cmd_type;

   // classified item handed from front to back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_swapped;
      logic       tx_is_idle;
      logic [7:0] bus_swapped;
      logic       bus_is_idle;
   } item_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       drive_data;
      logic       init_line;
      logic [2:0] tx_status;
      logic       tx_done;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic [9:0] rx_count;
      logic       rx_overwrite;
      logic       rx_busy;
   } rsp_type;

endpackage

// ----- rtl/core/parallel_byte_link_handshake.sv -----
// Top level of the parallel byte link with INIT strobe handshake.
// An accepted item passes through the queue and then the result register before result valid.
// One item per cycle unless rsp_tready stalls, set by the execute stage and ring read port.
// A two-entry queue lets input acceptance continue while a result waits on rsp_tready.
// Reset is synchronous, active high; it clears control state and loads configuration defaults.
// Ring contents are not cleared; the fill count guards every read, so no clearing pass.
`timescale 1ns / 1ps

module parallel_byte_link_handshake #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plbh_pkg::REQ_TDATA_W-1:0]    req_tdata,  // tx_byte, bus_data
   input  logic [2:0]                          req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // data_out, drive_data, init_line, tx_status, tx_done, rx_byte, rx_valid,
   // rx_count, rx_overwrite, rx_busy, zero fill
   output logic [plbh_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [plbh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plbh_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   plbh_pkg::item_type front_item, queue_item;
   plbh_pkg::rsp_type  rsp;
   logic queue_full, queue_valid, back_take;

   plbh_front u_front (
      .req_type (req_tuser),
      .tx_byte  (req_tdata[7:0]),
      .bus_data (req_tdata[15:8]),
      .item     (front_item)
   );

   assign req_tready = !queue_full;

   plbh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && req_tready),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (back_take),
      .out_valid (queue_valid),
      .out_item  (queue_item)
   );

   plbh_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (queue_valid),
      .in_item   (queue_item),
      .in_take   (back_take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.rx_busy, rsp.rx_overwrite, rsp.rx_count, rsp.rx_valid,
                       rsp.rx_byte, rsp.tx_done, rsp.tx_status, rsp.init_line,
                       rsp.drive_data, rsp.data_out};

endmodule

// ----- rtl/core/plbh_front.sv -----
// Front end: decodes request items into link commands, swaps CR and LF and flags idle bytes.
`timescale 1ns / 1ps

module plbh_front (
   input  logic [2:0]        req_type,
   input  logic [7:0]        tx_byte,
   input  logic [7:0]        bus_data,
   output plbh_pkg::item_type item
);

   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_SEND   = 3'd1;
   localparam logic [2:0] REQ_POP    = 3'd2;
   localparam logic [2:0] REQ_REMOTE = 3'd3;
   localparam logic [2:0] REQ_ABORT  = 3'd4;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   function automatic logic [7:0] swap_crlf(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b == CHAR_CR) r = CHAR_LF;
      else if (b == CHAR_LF) r = CHAR_CR;
      return r;
   endfunction

   always_comb begin
      unique case (req_type)
         REQ_TICK:   item.cmd = plbh_pkg::CMD_TICK;
         REQ_SEND:   item.cmd = plbh_pkg::CMD_SEND;
         REQ_POP:    item.cmd = plbh_pkg::CMD_POP;
         REQ_REMOTE: item.cmd = plbh_pkg::CMD_REMOTE;
         REQ_ABORT:  item.cmd = plbh_pkg::CMD_ABORT;
         default:    item.cmd = plbh_pkg::CMD_NOP;
      endcase
      item.tx_swapped  = swap_crlf(tx_byte);
      item.tx_is_idle  = (tx_byte == plbh_pkg::BYTE_IDLE);
      item.bus_swapped = swap_crlf(bus_data);
      item.bus_is_idle = (bus_data == plbh_pkg::BYTE_IDLE);
   end

endmodule

// ----- rtl/core/plbh_queue.sv -----
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module plbh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  plbh_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               out_valid,
   output plbh_pkg::item_type out_item
);

   localparam int PTR_W = $clog2(plbh_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(plbh_pkg::QUEUE_DEPTH + 1);

   plbh_pkg::item_type entry_ff [plbh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(plbh_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == CNT_W'(plbh_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/plbh_back.sv -----
// Back end: link and receive sequencing, receive ring and result register.
`timescale 1ns / 1ps

module plbh_back #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [plbh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plbh_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                in_valid,
   input  plbh_pkg::item_type                  in_item,
   output logic                                in_take,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output plbh_pkg::rsp_type                   rsp
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   typedef enum logic [1:0] {LINK_IDLE, LINK_XFER, LINK_WAIT} link_type;
   typedef enum logic {RX_IDLE, RX_POLL} rx_type;

   logic [7:0] ring_mem [RING_DEPTH];

   logic        reader_en_ff;
   logic [15:0] xfer_ticks_ff, proc_ticks_ff;
   logic [7:0]  rx_timeout_ff;

   link_type         link_ff, link_in;
   logic [15:0]      phase_cnt_ff, phase_cnt_in;
   logic             pending_ff, pending_in;
   rx_type           rx_ff, rx_in;
   logic [7:0]       poll_cnt_ff, poll_cnt_in;
   logic [7:0]       held_ff, held_in;
   plbh_pkg::tx_status_type outcome_ff, outcome_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff;
   plbh_pkg::rsp_type rsp_ff, rsp_in;
   logic             hit_ff;
   logic [7:0]       rd_data_ff;

   logic        push, done, over, hit;
   logic [15:0] xfer_lim, proc_lim;
   logic [7:0]  rx_lim;
   logic [IDX_W+9:0] count_ext;

   function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   assign in_take   = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp         = rsp_ff;
      rsp.rx_byte = hit_ff ? rd_data_ff : 8'd0;
   end

   assign xfer_lim = (xfer_ticks_ff == '0) ? 16'd1 : xfer_ticks_ff;
   assign proc_lim = (proc_ticks_ff == '0) ? 16'd1 : proc_ticks_ff;
   assign rx_lim   = (rx_timeout_ff == '0) ? 8'd1 : rx_timeout_ff;

   always_comb begin
      link_in      = link_ff;
      phase_cnt_in = phase_cnt_ff;
      pending_in   = pending_ff;
      rx_in        = rx_ff;
      poll_cnt_in  = poll_cnt_ff;
      held_in      = held_ff;
      outcome_in   = outcome_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      count_in     = count_ff;
      push         = 1'b0;
      done         = 1'b0;
      over         = 1'b0;
      hit          = 1'b0;

      unique case (in_item.cmd)
         plbh_pkg::CMD_TICK: begin
            if (rx_ff == RX_POLL) begin
               poll_cnt_in = poll_cnt_ff + 1'b1;
               if (!in_item.bus_is_idle || poll_cnt_in >= rx_lim) begin
                  push  = reader_en_ff;
                  rx_in = RX_IDLE;
               end
            end
            if (link_ff == LINK_XFER) begin
               phase_cnt_in = phase_cnt_ff + 1'b1;
               if (phase_cnt_in >= xfer_lim) begin
                  link_in      = LINK_WAIT;
                  phase_cnt_in = '0;
                  if (pending_ff) begin
                     pending_in = 1'b0;
                     if (rx_in == RX_IDLE) begin
                        rx_in       = RX_POLL;
                        poll_cnt_in = '0;
                     end
                  end
               end
            end else if (link_ff == LINK_WAIT) begin
               phase_cnt_in = phase_cnt_ff + 1'b1;
               if (phase_cnt_in >= proc_lim) begin
                  link_in      = LINK_IDLE;
                  phase_cnt_in = '0;
                  outcome_in   = plbh_pkg::TX_OK;
                  done         = 1'b1;
               end
            end
         end
         plbh_pkg::CMD_SEND: begin
            if (link_ff == LINK_IDLE && rx_ff == RX_IDLE) begin
               if (in_item.tx_is_idle) begin
                  outcome_in = plbh_pkg::TX_OK;
                  done       = 1'b1;
               end else begin
                  held_in      = in_item.tx_swapped;
                  pending_in   = 1'b0;
                  link_in      = LINK_XFER;
                  phase_cnt_in = '0;
               end
            end
         end
         plbh_pkg::CMD_POP: begin
            if (count_ff != '0) begin
               hit       = 1'b1;
               rd_idx_in = bump(rd_idx_ff);
               count_in  = count_ff - 1'b1;
            end
         end
         plbh_pkg::CMD_REMOTE: begin
            if (link_ff == LINK_XFER) begin
               pending_in = 1'b1;
            end else if (rx_ff == RX_IDLE) begin
               rx_in       = RX_POLL;
               poll_cnt_in = '0;
            end
         end
         plbh_pkg::CMD_ABORT: begin
            if (link_ff == LINK_WAIT) begin
               link_in      = LINK_IDLE;
               phase_cnt_in = '0;
               outcome_in   = plbh_pkg::TX_INTR;
               done         = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // ring push; full ring drops its oldest entry
      if (push) begin
         wr_idx_in = bump(wr_idx_ff);
         if (count_ff == IDX_W'(RING_DEPTH - 1)) begin
            over      = 1'b1;
            rd_idx_in = bump(rd_idx_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end

      count_ext = {10'd0, count_in};

      rsp_in.data_out     = (link_in == LINK_XFER) ? held_in : 8'd0;
      rsp_in.drive_data   = (link_in == LINK_XFER);
      rsp_in.init_line    = !((link_in == LINK_XFER) || (rx_in == RX_POLL));
      if (link_in == LINK_XFER) rsp_in.tx_status = plbh_pkg::TX_XFER;
      else if (link_in == LINK_WAIT) rsp_in.tx_status = plbh_pkg::TX_WAIT;
      else rsp_in.tx_status = outcome_in;
      rsp_in.tx_done      = done;
      rsp_in.rx_byte      = 8'd0;
      rsp_in.rx_valid     = hit;
      rsp_in.rx_count     = count_ext[9:0];
      rsp_in.rx_overwrite = over;
      rsp_in.rx_busy      = (rx_in == RX_POLL);
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         if (push) ring_mem[wr_idx_ff] <= in_item.bus_swapped;
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reader_en_ff  <= 1'b0;
         xfer_ticks_ff <= 16'd250;
         proc_ticks_ff <= 16'd30000;
         rx_timeout_ff <= 8'd100;
         link_ff       <= LINK_IDLE;
         phase_cnt_ff  <= '0;
         pending_ff    <= 1'b0;
         rx_ff         <= RX_IDLE;
         poll_cnt_ff   <= '0;
         held_ff       <= '0;
         outcome_ff    <= plbh_pkg::TX_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               plbh_pkg::CSR_READER_EN:  reader_en_ff  <= csr_wdata[0];
               plbh_pkg::CSR_XFER_TICKS: xfer_ticks_ff <= csr_wdata;
               plbh_pkg::CSR_PROC_TICKS: proc_ticks_ff <= csr_wdata;
               plbh_pkg::CSR_RX_TIMEOUT: rx_timeout_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         if (in_take) begin
            link_ff      <= link_in;
            phase_cnt_ff <= phase_cnt_in;
            pending_ff   <= pending_in;
            rx_ff        <= rx_in;
            poll_cnt_ff  <= poll_cnt_in;
            held_ff      <= held_in;
            outcome_ff   <= outcome_in;
            wr_idx_ff    <= wr_idx_in;
            rd_idx_ff    <= rd_idx_in;
            count_ff     <= count_in;
            rsp_ff       <= rsp_in;
            hit_ff       <= hit;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- rtl/core/plbh_checker.sv -----
// Port-level assertions for the parallel byte link, bound to the top level.
`timescale 1ns / 1ps

module plbh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [plbh_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output stall");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |->
         (rsp_tdata[12:10] == plbh_pkg::TX_OK) || (rsp_tdata[12:10] == plbh_pkg::TX_INTR))
      else $error("send finished with a busy status");

   a_drive_init: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |->
         !rsp_tdata[9] && (rsp_tdata[12:10] == plbh_pkg::TX_XFER))
      else $error("data driven outside transfer");

endmodule

bind parallel_byte_link_handshake plbh_checker u_plbh_checker (.*);

// ----- verif/tb.sv -----
// Self-checking stream testbench for the parallel byte link with INIT handshake.
`timescale 1ns / 1ps

module tb;

   localparam int RING_SLOTS   = 1024;
   localparam int QUIET_LIMIT  = 1000;
   localparam int LONG_STALL   = 60;

   localparam logic [2:0] REQ_CODE_MAX = '1;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_LF      = 8'd10;

   typedef enum logic [1:0] {LINK_IDLE, LINK_TRANSFER, LINK_WAIT} link_phase_type;

   // first member sits in the highest bits, so data_out lands at bit 0
   typedef struct packed {
      logic       rx_busy;
      logic       rx_overwrite;
      logic [9:0] rx_count;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_done;
      logic [2:0] tx_status;
      logic       init_line;
      logic       drive_data;
      logic [7:0] data_out;
   } link_result_type;

   localparam int RESULT_W = $bits(link_result_type);

   typedef struct {
      logic [2:0] code;
      logic [7:0] tx_byte;
      logic [7:0] bus;
   } link_item_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [plbh_pkg::REQ_TDATA_W-1:0] req_tdata = '0;   // tx_byte, bus_data
   logic [2:0]                       req_tuser = '0;   // req_type
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // data_out, drive_data, init_line, tx_status, tx_done, rx_byte, rx_valid,
   // rx_count, rx_overwrite, rx_busy, zero fill
   logic [plbh_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [plbh_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [plbh_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   parallel_byte_link_handshake DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // link state mirror
   bit                      reader_on;
   logic [15:0]             xfer_len, settle_len;
   logic [7:0]              poll_limit;
   link_phase_type          link_phase;
   logic [15:0]             phase_cnt;
   bit                      remote_waiting;
   bit                      polling;
   logic [7:0]              poll_cnt;
   logic [7:0]              bus_last;
   logic [7:0]              out_byte;
   plbh_pkg::tx_status_type last_outcome;
   logic [7:0]              ring_bytes [RING_SLOTS];
   logic [9:0]              wr_ptr, rd_ptr;

   link_item_type   request_backlog[$];
   link_result_type awaited_responses[$];

   int queued, items_accepted, results_checked, mismatches;
   int sends_delivered, sends_aborted, sends_skipped, rx_timeouts, bytes_popped, overwrites;
   int gap_pct, stall_pct;
   int stalls_asked, stalls_done, long_stall_left, quiet_cycles;

   function automatic logic [7:0] swap_crlf(logic [7:0] b);
      if (b == CHAR_CR) return CHAR_LF;
      if (b == CHAR_LF) return CHAR_CR;
      return b;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [9:0] ring_fill();
      return wr_ptr - rd_ptr;
   endfunction

   function automatic bit ring_push(logic [7:0] v);
      bit dropped;
      dropped = (ring_fill() == 10'(RING_SLOTS - 1));
      if (dropped) rd_ptr = rd_ptr + 1'b1;
      ring_bytes[wr_ptr] = v;
      wr_ptr = wr_ptr + 1'b1;
      return dropped;
   endfunction

   function automatic void start_poll();
      polling  = 1'b1;
      poll_cnt = '0;
      bus_last = plbh_pkg::BYTE_IDLE;
   endfunction

   function automatic link_result_type predict_link_response(logic [2:0] code,
                                                             logic [7:0] txb,
                                                             logic [7:0] bus);
      link_result_type r;
      r = '0;
      case (code)
         plbh_pkg::CMD_TICK: begin
            if (polling) begin
               poll_cnt = poll_cnt + 1'b1;
               bus_last = bus;
               if (bus_last != plbh_pkg::BYTE_IDLE ||
                   poll_cnt >= ((poll_limit == 0) ? 8'd1 : poll_limit)) begin
                  if (bus_last == plbh_pkg::BYTE_IDLE) rx_timeouts++;
                  if (reader_on) r.rx_overwrite = ring_push(swap_crlf(bus_last));
                  overwrites += r.rx_overwrite;
                  polling = 1'b0;
               end
            end
            if (link_phase == LINK_TRANSFER) begin
               phase_cnt = phase_cnt + 1'b1;
               if (phase_cnt >= ((xfer_len == 0) ? 16'd1 : xfer_len)) begin
                  link_phase = LINK_WAIT;
                  phase_cnt  = '0;
                  if (remote_waiting) begin
                     remote_waiting = 1'b0;
                     if (!polling) start_poll();
                  end
               end
            end else if (link_phase == LINK_WAIT) begin
               phase_cnt = phase_cnt + 1'b1;
               if (phase_cnt >= ((settle_len == 0) ? 16'd1 : settle_len)) begin
                  link_phase   = LINK_IDLE;
                  phase_cnt    = '0;
                  last_outcome = plbh_pkg::TX_OK;
                  r.tx_done    = 1'b1;
                  sends_delivered++;
               end
            end
         end
         plbh_pkg::CMD_SEND: begin
            if (link_phase == LINK_IDLE && !polling) begin
               if (txb == plbh_pkg::BYTE_IDLE) begin
                  last_outcome = plbh_pkg::TX_OK;
                  r.tx_done    = 1'b1;
                  sends_skipped++;
               end else begin
                  out_byte       = swap_crlf(txb);
                  remote_waiting = 1'b0;
                  link_phase     = LINK_TRANSFER;
                  phase_cnt      = '0;
               end
            end
         end
         plbh_pkg::CMD_POP: begin
            if (ring_fill() != 0) begin
               r.rx_byte  = ring_bytes[rd_ptr];
               r.rx_valid = 1'b1;
               rd_ptr     = rd_ptr + 1'b1;
               bytes_popped++;
            end
         end
         plbh_pkg::CMD_REMOTE: begin
            if (link_phase == LINK_TRANSFER) remote_waiting = 1'b1;
            else if (!polling) start_poll();
         end
         plbh_pkg::CMD_ABORT: begin
            if (link_phase == LINK_WAIT) begin
               link_phase   = LINK_IDLE;
               phase_cnt    = '0;
               last_outcome = plbh_pkg::TX_INTR;
               r.tx_done    = 1'b1;
               sends_aborted++;
            end
         end
         default: ;
      endcase
      case (link_phase)
         LINK_TRANSFER: r.tx_status = plbh_pkg::TX_XFER;
         LINK_WAIT:     r.tx_status = plbh_pkg::TX_WAIT;
         default:       r.tx_status = last_outcome;
      endcase
      r.data_out   = (link_phase == LINK_TRANSFER) ? out_byte : 8'd0;
      r.drive_data = (link_phase == LINK_TRANSFER);
      r.init_line  = !(link_phase == LINK_TRANSFER || polling);
      r.rx_count   = ring_fill();
      r.rx_busy    = polling;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // driver
   always @(posedge clock) begin : driver
      link_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_responses.push_back(
               predict_link_response(req_tuser, req_tdata[7:0], req_tdata[15:8]));
            items_accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
               nxt = request_backlog.pop_front();
               req_tuser  <= nxt.code;
               req_tdata  <= {nxt.bus, nxt.tx_byte};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      link_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = link_result_type'(rsp_tdata[RESULT_W-1:0]);
            if (awaited_responses.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item, expected none, got 0x%0h", $time, rsp_tdata);
            end else begin
               want = awaited_responses.pop_front();
               check_field("data_out", want.data_out, got.data_out);
               check_field("drive_data", want.drive_data, got.drive_data);
               check_field("init_line", want.init_line, got.init_line);
               check_field("tx_status", want.tx_status, got.tx_status);
               check_field("tx_done", want.tx_done, got.tx_done);
               check_field("rx_byte", want.rx_byte, got.rx_byte);
               check_field("rx_valid", want.rx_valid, got.rx_valid);
               check_field("rx_count", want.rx_count, got.rx_count);
               check_field("rx_overwrite", want.rx_overwrite, got.rx_overwrite);
               check_field("rx_busy", want.rx_busy, got.rx_busy);
               check_field("fill", 0, rsp_tdata[plbh_pkg::RSP_TDATA_W-1:RESULT_W]);
               results_checked++;
            end
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_tready <= 1'b0;
         end else if (stalls_asked != stalls_done) begin
            stalls_done++;
            long_stall_left = LONG_STALL;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic enqueue(logic [2:0] code, logic [7:0] txb, logic [7:0] bus);
      link_item_type it;
      it.code    = code;
      it.tx_byte = txb;
      it.bus     = bus;
      request_backlog.push_back(it);
      queued++;
   endtask

   function automatic logic [7:0] pick_tx();
      case ($urandom_range(9))
         0:       return plbh_pkg::BYTE_IDLE;
         1:       return CHAR_CR;
         2:       return CHAR_LF;
         3:       return 8'd0;
         default: return rand_byte();
      endcase
   endfunction

   function automatic logic [7:0] pick_bus();
      case ($urandom_range(9))
         0, 1, 2: return plbh_pkg::BYTE_IDLE;
         3:       return CHAR_CR;
         4:       return CHAR_LF;
         5:       return 8'd0;
         default: return rand_byte();
      endcase
   endfunction

   task automatic send_burst();
      int unsigned xfer, settle, n, remote_at, i;
      xfer   = (xfer_len == 0) ? 1 : xfer_len;
      settle = (settle_len == 0) ? 1 : settle_len;
      enqueue(plbh_pkg::CMD_SEND, pick_tx(), rand_byte());
      n = xfer + $urandom_range(settle + 1);
      remote_at = ($urandom_range(2) == 0) ? $urandom_range(xfer) : n + 1;
      for (i = 0; i < n; i++) begin
         if (i == remote_at) enqueue(plbh_pkg::CMD_REMOTE, rand_byte(), rand_byte());
         if ($urandom_range(15) == 0) enqueue(plbh_pkg::CMD_SEND, pick_tx(), rand_byte());
         enqueue(plbh_pkg::CMD_TICK, rand_byte(), pick_bus());
      end
      if ($urandom_range(2) == 0) enqueue(plbh_pkg::CMD_ABORT, rand_byte(), rand_byte());
   endtask

   task automatic receive_burst();
      int unsigned n;
      enqueue(plbh_pkg::CMD_REMOTE, rand_byte(), rand_byte());
      n = $urandom_range((poll_limit == 0) ? 1 : poll_limit);
      repeat (n) enqueue(plbh_pkg::CMD_TICK, rand_byte(), plbh_pkg::BYTE_IDLE);
      enqueue(plbh_pkg::CMD_TICK, rand_byte(), pick_bus());
   endtask

   task automatic random_phase(int target);
      int first;
      int unsigned pick;
      first = queued;
      while (queued - first < target) begin
         pick = $urandom_range(99);
         if (pick < 35) send_burst();
         else if (pick < 70) receive_burst();
         else if (pick < 85) begin
            repeat ($urandom_range(1, 3)) enqueue(plbh_pkg::CMD_POP, rand_byte(), rand_byte());
         end
         else enqueue(3'($urandom_range(REQ_CODE_MAX)), rand_byte(), rand_byte());
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_tvalid || rsp_tvalid ||
             awaited_responses.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(logic [plbh_pkg::CSR_IDX_W-1:0] idx,
                            logic [plbh_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         plbh_pkg::CSR_READER_EN:  reader_on  = val[0];
         plbh_pkg::CSR_XFER_TICKS: xfer_len   = val;
         plbh_pkg::CSR_PROC_TICKS: settle_len = val;
         plbh_pkg::CSR_RX_TIMEOUT: poll_limit = val[7:0];
         default: ;
      endcase
   endtask

   task automatic start_phase(logic [15:0] reader, logic [15:0] xfer, logic [15:0] settle,
                              logic [15:0] timeout, int gap, int stall);
      wait_idle();
      write_reg(plbh_pkg::CSR_READER_EN, reader);
      write_reg(plbh_pkg::CSR_XFER_TICKS, xfer);
      write_reg(plbh_pkg::CSR_PROC_TICKS, settle);
      write_reg(plbh_pkg::CSR_RX_TIMEOUT, timeout);
      gap_pct   = gap;
      stall_pct = stall;
      @(negedge clock);
   endtask

   initial begin
      int i;
      reader_on      = 1'b0;
      xfer_len       = 16'd250;
      settle_len     = 16'd30000;
      poll_limit     = 8'd100;
      link_phase     = LINK_IDLE;
      phase_cnt      = '0;
      remote_waiting = 1'b0;
      polling        = 1'b0;
      poll_cnt       = '0;
      bus_last       = plbh_pkg::BYTE_IDLE;
      out_byte       = '0;
      last_outcome   = plbh_pkg::TX_IDLE;
      wr_ptr         = '0;
      rd_ptr         = '0;
      gap_pct        = 0;
      stall_pct      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: reader detached, empty ring, skipped send
      enqueue(plbh_pkg::CMD_POP, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_REMOTE, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_TICK, 8'h00, 8'h41);
      enqueue(plbh_pkg::CMD_SEND, plbh_pkg::BYTE_IDLE, 8'h00);
      enqueue(plbh_pkg::CMD_TICK, 8'hFF, 8'hFF);

      start_phase(16'd1, 16'd2, 16'd3, 16'd3, 0, 0);
      enqueue(plbh_pkg::CMD_SEND, CHAR_CR, 8'h00);
      enqueue(plbh_pkg::CMD_TICK, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_REMOTE, 8'h00, 8'h00);     // held until transfer ends
      enqueue(plbh_pkg::CMD_SEND, 8'h55, 8'h00);       // busy, ignored
      enqueue(plbh_pkg::CMD_TICK, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_TICK, 8'h00, plbh_pkg::BYTE_IDLE);
      enqueue(plbh_pkg::CMD_TICK, 8'h00, CHAR_LF);
      enqueue(plbh_pkg::CMD_ABORT, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_ABORT, 8'h00, 8'h00);      // outside wait, ignored
      enqueue(plbh_pkg::CMD_REMOTE, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_REMOTE, 8'h00, 8'h00);     // already receiving
      repeat (3) enqueue(plbh_pkg::CMD_TICK, 8'h00, plbh_pkg::BYTE_IDLE);   // timeout stores 0xFF
      repeat (3) enqueue(plbh_pkg::CMD_POP, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_SEND, CHAR_LF, 8'h00);
      repeat (5) enqueue(plbh_pkg::CMD_TICK, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_SEND, 8'hFE, 8'h00);
      enqueue(plbh_pkg::CMD_REMOTE, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_TICK, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_POP, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_NOP, 8'hFF, 8'hFF);
      enqueue(REQ_CODE_MAX - 3'd1, 8'h5A, 8'hA5);
      enqueue(REQ_CODE_MAX, 8'hFF, 8'hFF);

      start_phase(16'd1, 16'd1, 16'd1, 16'd1, 0, 0);
      random_phase(100);
      start_phase(16'd1, 16'd0, 16'd0, 16'd0, 59, 0);
      random_phase(100);
      start_phase(16'd0, 16'($urandom_range(2, 8)), 16'($urandom_range(2, 12)),
                  16'($urandom_range(2, 6)), 0, 59);
      random_phase(100);
      start_phase(16'd1, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 20)),
                  16'($urandom_range(1, 8)), 14, 14);
      random_phase(100);
      stalls_asked++;
      start_phase(16'd1, 16'd3, 16'd40, 16'd20, 0, 0);
      random_phase(100);
      start_phase({15'($urandom_range(16'h7FFF)), 1'b1}, 16'($urandom_range(1, 10)),
                  16'($urandom_range(1, 15)),
                  {8'($urandom_range(8'hFF)), 8'($urandom_range(1, 9))}, 59, 0);
      random_phase(100);

      // wide counters: a transfer past 8 bits, then a poll that runs to its limit
      start_phase(16'd1, 16'd260, 16'hFFFF, 16'd255, 0, 0);
      enqueue(plbh_pkg::CMD_SEND, 8'h80, 8'h00);
      for (i = 0; i < 260; i++) begin
         if (i == 100) enqueue(plbh_pkg::CMD_REMOTE, rand_byte(), rand_byte());
         enqueue(plbh_pkg::CMD_TICK, rand_byte(), rand_byte());
      end
      repeat (255) enqueue(plbh_pkg::CMD_TICK, rand_byte(), plbh_pkg::BYTE_IDLE);
      enqueue(plbh_pkg::CMD_ABORT, 8'h00, 8'h00);
      enqueue(plbh_pkg::CMD_POP, 8'h00, 8'h00);

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d items: %0d sends delivered, %0d aborted, %0d skipped, %0d rx timeouts",
               items_accepted, sends_delivered, sends_aborted, sends_skipped, rx_timeouts);
      $display("Ring saw %0d pops with data and %0d overwrites; %0d results checked",
               bytes_popped, overwrites, results_checked);
      if (mismatches == 0 && awaited_responses.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
